FILE: hw/rtl/hte_pkg.sv
// ============================================================================
// hte_pkg - shared types and constants for the Huffman tree expander
// Command codes, link and field widths, node entry layout, walk states.
// ============================================================================
`default_nettype none

package hte_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned LINK_W   = 9;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SYM_W    = 8;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned BITCNT_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    // last bit position of a byte
    localparam logic [BITCNT_W-1:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [LINK_W-1:0] one_link;
        logic [LINK_W-1:0] zero_link;
    } t_node;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/hte_if.sv
// ============================================================================
// hte_if - valid/ready channels of the Huffman tree expander
// Input word channel (commands, table nodes, data bytes) and symbol channel.
// ============================================================================
`default_nettype none

interface hte_in_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::CMD_W-1:0]     cmd;
    logic [hte_pkg::INDEX_W-1:0]   node_index;
    logic [hte_pkg::LINK_W-1:0]    zero_link;
    logic [hte_pkg::LINK_W-1:0]    one_link;
    logic [hte_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, cmd, node_index, zero_link, one_link, data_byte,
                    input  ready);
    modport sink   (input  valid, cmd, node_index, zero_link, one_link, data_byte,
                    output ready);
endinterface

interface hte_out_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::SYM_W-1:0]     symbol;
    logic                          run_last;
    logic                          done_res;

    modport source (output valid, symbol, run_last, done_res, input ready);
    modport sink   (input  valid, symbol, run_last, done_res, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/huffman_tree_expander_core.sv
// ============================================================================
// huffman_tree_expander_core - binary-tree Huffman decoder
// Loads a node table, then walks data bytes bit-serially, LSB first, and
// emits one symbol word per leaf reached, up to the configured length.
// ============================================================================
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          cmd, node_index, zero_link, one_link, data_byte
//  o_out     out  valid/ready          symbol, run_last, done_res
//  i_cfg     in   i_cfg_we (no wait)   i_cfg_data = expanded_length
//
//  Load, start and data words are accepted in idle. A data word is then walked
//  one bit per walk cycle unless the output holds the walk (once the length is
//  reached, the walk ends the byte early) and closed in flush; the next word
//  is taken only back in idle. The walk is bounded by the table read, which
//  feeds the next node address back into the same memory port each cycle.
//  A stalled output holds the walk when a leaf is found while the holding
//  slot and the output register are both full, and holds the flush until
//  the output register frees.
//  Reset is synchronous, active low: walk at the head node, count and length
//  zero. The node table is not cleared and holds garbage until loaded.
//
`default_nettype none

module huffman_tree_expander_core #(
    parameter int unsigned NODE_COUNT = 255
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    hte_in_if.sink                             i_in,
    hte_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [hte_pkg::COUNT_W-1:0]   i_cfg_data
);

    localparam int unsigned NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    // node limit compared against 9-bit links and 8-bit indexes
    localparam logic [hte_pkg::LINK_W-1:0] NODE_LIM  = hte_pkg::LINK_W'(NODE_COUNT);
    localparam logic [NODE_W-1:0]          HEAD_NODE = NODE_W'(NODE_COUNT - 1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    hte_pkg::t_state                 r_state, n_state;
    hte_pkg::t_node                  r_mem [NODE_COUNT];
    hte_pkg::t_node                  r_entry;          // table word of r_node
    logic [NODE_W-1:0]               r_node,   n_node;
    logic [hte_pkg::COUNT_W-1:0]     r_count,  n_count;
    logic [hte_pkg::COUNT_W-1:0]     r_length;
    logic [hte_pkg::BYTE_W-1:0]      r_bits,   n_bits;  // data shift register
    logic [hte_pkg::BITCNT_W-1:0]    r_bitcnt, n_bitcnt;

    // one-deep holding slot: a symbol waits here until we know if it is last
    logic                            r_pend_valid, n_pend_valid;
    logic [hte_pkg::SYM_W-1:0]       r_pend_sym,   n_pend_sym;
    logic                            r_pend_done,  n_pend_done;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [hte_pkg::SYM_W-1:0]       r_out_sym,   n_out_sym;
    logic                            r_out_last,  n_out_last;
    logic                            r_out_done,  n_out_done;

    // ------------------------------------------------------------------
    // walk decode
    // ------------------------------------------------------------------
    logic                            w_in_acc;
    logic                            w_out_free;
    logic                            w_complete;
    logic [hte_pkg::LINK_W-1:0]      w_link;
    logic                            w_is_leaf;
    logic                            w_link_ok;
    logic                            w_step;
    logic [hte_pkg::COUNT_W-1:0]     w_count_inc;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_complete  = (r_count >= r_length);
    assign w_link      = r_bits[0] ? r_entry.one_link : r_entry.zero_link;
    assign w_is_leaf   = !w_link[hte_pkg::LINK_W-1];
    assign w_link_ok   = ({1'b0, w_link[hte_pkg::LINK_W-2:0]} < NODE_LIM);
    assign w_count_inc = r_count + hte_pkg::COUNT_W'(1);
    // a bit is consumed unless the length is reached or a leaf must wait for room in the output
    assign w_step      = (r_state == hte_pkg::ST_WALK) && !w_complete &&
                         (!w_is_leaf || !r_pend_valid || w_out_free);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hte_pkg::ST_IDLE: begin
                if (w_in_acc && (i_in.cmd == hte_pkg::CMD_DATA)) begin
                    n_state = hte_pkg::ST_WALK;
                end
            end
            hte_pkg::ST_WALK: begin
                if (w_complete || (w_step && (r_bitcnt == hte_pkg::LAST_BIT))) begin
                    n_state = hte_pkg::ST_FLUSH;
                end
            end
            hte_pkg::ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = hte_pkg::ST_IDLE;
                end
            end
            default: n_state = hte_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_node       = r_node;
        n_count      = r_count;
        n_bits       = r_bits;
        n_bitcnt     = r_bitcnt;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_done  = r_pend_done;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_sym    = r_out_sym;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;

        unique case (r_state)
            hte_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.cmd)
                        hte_pkg::CMD_START: begin
                            n_node  = HEAD_NODE;
                            n_count = '0;
                        end
                        hte_pkg::CMD_DATA: begin
                            n_bits   = i_in.data_byte;
                            n_bitcnt = '0;
                        end
                        default: ;  // loads go to the memory; unknown words dropped
                    endcase
                end
            end
            hte_pkg::ST_WALK: begin
                if (w_step) begin
                    n_bits   = r_bits >> 1;
                    n_bitcnt = r_bitcnt + hte_pkg::BITCNT_W'(1);
                    if (w_is_leaf) begin
                        // earlier symbol of this word is not the last one
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_sym   = r_pend_sym;
                            n_out_last  = 1'b0;
                            n_out_done  = r_pend_done;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_sym   = w_link[hte_pkg::SYM_W-1:0];
                        n_pend_done  = (w_count_inc == r_length);
                        n_count      = w_count_inc;
                        n_node       = HEAD_NODE;
                    end else if (w_link_ok) begin
                        n_node = w_link[NODE_W-1:0];
                    end else begin
                        // link past the table: restart at head, no symbol
                        n_node = HEAD_NODE;
                    end
                end
            end
            hte_pkg::ST_FLUSH: begin
                if (r_pend_valid && w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sym    = r_pend_sym;
                    n_out_last   = 1'b1;
                    n_out_done   = r_pend_done;
                    n_pend_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready     = (r_state == hte_pkg::ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.symbol   = r_out_sym;
    assign o_out.run_last = r_out_last;
    assign o_out.done_res = r_out_done;

    // ------------------------------------------------------------------
    // node table: written by loads, read every cycle at the next node so
    // the entry is ready for the following bit
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.cmd == hte_pkg::CMD_LOAD) &&
            ({1'b0, i_in.node_index} < NODE_LIM)) begin
            r_mem[i_in.node_index[NODE_W-1:0]] <= '{one_link:  i_in.one_link,
                                                    zero_link: i_in.zero_link};
        end
        r_entry <= r_mem[n_node];
    end

    // ------------------------------------------------------------------
    // control and payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hte_pkg::ST_IDLE;
            r_node       <= HEAD_NODE;
            r_count      <= '0;
            r_length     <= '0;
            r_bitcnt     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node       <= n_node;
            r_count      <= n_count;
            r_bitcnt     <= n_bitcnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits      <= n_bits;
        r_pend_sym  <= n_pend_sym;
        r_pend_done <= n_pend_done;
        r_out_sym   <= n_out_sym;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_node_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NODE_W + 1)'(r_node) < (NODE_W + 1)'(NODE_COUNT))
        else $error("walk node outside table");

    a_data_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.cmd == hte_pkg::CMD_DATA)) |=> (r_state == hte_pkg::ST_WALK))
        else $error("data word did not start a walk");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hte_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("symbol left pending after walk");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_sym)))
        else $error("stalled output word overwritten");

endmodule

`default_nettype wire
